@@ src/assert_macros.svh @@
// assertion macros shared by the allocator rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cba_pkg.sv @@
// shared codes, widths and divider types of the circular block allocator
// no dependencies
package cba_pkg;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 33;

    localparam logic [1:0] OP_ALLOC     = 2'd0;
    localparam logic [1:0] OP_FREE      = 2'd1;
    localparam logic [1:0] OP_TXN_BEGIN = 2'd2;
    localparam logic [1:0] OP_TXN_END   = 2'd3;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_TXN   = 2'd2;
    localparam logic [1:0] KIND_GRANT = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WAITING   = 3'd1;
    localparam logic [2:0] ST_NULL      = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_BAD_ALIGN = 3'd4;
    localparam logic [2:0] ST_BAD_FREE  = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    localparam logic [32:0] POOL_RESET = 33'd65536;
    localparam logic [32:0] POOL_MAX   = 33'h1_0000_0000;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

endpackage

@@ src/cba_if.sv @@
// request and response channel interfaces of the allocator
// no dependencies
interface cba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] block_size;
    logic [16:0] align;
    logic [31:0] free_offset;

    modport source (output valid, op, block_size, align, free_offset, input ready);
    modport sink   (input valid, op, block_size, align, free_offset, output ready);
endinterface

interface cba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [31:0] offset;
    logic        last;

    modport source (output valid, kind, status, offset, last, input ready);
    modport sink   (input valid, kind, status, offset, last, output ready);
endinterface

@@ src/cba_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
// depends on cba_pkg for widths and request/response structs
module cba_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cba_pkg::div_req_t req,
    output cba_pkg::div_rsp_t rsp
);

    localparam int DW = cba_pkg::DIVIDEND_W;
    localparam int VW = cba_pkg::DIVISOR_W;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   trial;
    logic          qbit;
    logic [VW-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DW-1]} - {1'b0, dvs_reg};
        qbit     = ~trial[VW];
        rem_next = qbit ? trial[VW-1:0] : {rem_reg[VW-2:0], quo_reg[DW-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DW-2:0], qbit};
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ src/circular_block_allocator.sv @@
// circular block allocator top level: sequencer, block table and waiting queue
// depends on cba_pkg, cba_if, cba_div and assert_macros.svh
//
// usage:
//   req channel carries one item per operation: allocate, free, begin or end
//   transaction. rsp channel returns one to 1 + MAX_WAITING items per request;
//   last marks the final one. a free reply is followed by deferred grants.
//   cfg_wr_en/cfg_wr_data write pool_size; the user must write it only while
//   the block is idle, and the block itself does not enforce it.
// timing:
//   one request at a time; req.ready is high only between requests.
//   every modulo or rounding goes through one shared divider.
//   allocate: up to six divisions; fast errors need none.
//   free: one division per table entry searched, then a scan of the MAX_WAITING
//   queue slots and a pass over the queue entries.
//   transaction begin needs no division; end needs one when a rewrap is pending.
// reset: table and queue empty, positions zero, pool_size 65536.
// stall: results sit in a single output register; the sequencer waits
//   while it is full and no result is dropped.
`include "assert_macros.svh"

module circular_block_allocator #(
    parameter int MAX_BLOCKS  = 16,
    parameter int MAX_WAITING = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [32:0] cfg_wr_data,
    cba_req_if.sink     req,
    cba_rsp_if.source   rsp
);

    localparam int BIDX_W  = $clog2(MAX_BLOCKS > 1 ? MAX_BLOCKS : 2);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int WIDX_W  = $clog2(MAX_WAITING > 1 ? MAX_WAITING : 2);
    localparam int WCNT_W  = $clog2(MAX_WAITING + 1);
    localparam int HEAD2   = (MAX_BLOCKS > 1) ? 1 : 0;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_AL_MODA, S_AL_MODA_W, S_AL_RA, S_AL_RA_W, S_AL_Q0, S_AL_Q0_W,
        S_AL_Q1, S_AL_Q1_W, S_AL_RB, S_AL_RB_W, S_AL_OFS, S_AL_OFS_W,
        S_AL_COMMIT,
        S_FR_DIV, S_FR_DIV_W, S_FR_MASK, S_FR_REPLY, S_FR_GRANT,
        S_TE, S_TE_W, S_REPLY
    } state_t;

    state_t state_reg;

    logic [32:0] ps_reg;
    logic [63:0] fill_reg, oldest_reg, txn_limit_reg, txn_bytes_reg;
    logic        txn_active_reg, rewrap_reg;
    logic [63:0] bst_reg [MAX_BLOCKS];
    logic [63:0] bsa_reg [MAX_BLOCKS];
    logic [CNT_W-1:0] live_cnt_reg;
    logic [63:0] wend_reg [MAX_WAITING];
    logic [31:0] wofs_reg [MAX_WAITING];
    logic [WCNT_W-1:0] wcnt_reg;

    logic [1:0]  op_reg;
    logic [31:0] nb_reg, fo_reg;
    logic [16:0] al_reg;
    logic [63:0] st_reg, sa_reg, en_reg, q0_reg, rup_reg;
    logic [31:0] ofs_reg;
    logic [BIDX_W-1:0] idx_reg;
    logic [WCNT_W-1:0] wj_reg, kept_reg;
    logic [MAX_WAITING-1:0] mask_reg;

    logic [1:0]  res_kind_reg;
    logic [2:0]  res_status_reg;
    logic [31:0] res_offset_reg;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [2:0]  out_status_reg;
    logic [31:0] out_offset_reg;
    logic        out_last_reg;

    cba_pkg::div_req_t div_req;
    cba_pkg::div_rsp_t div_rsp;

    logic [63:0] ps64, al64, rem64, oldest_lim, txn_sum, half_pool;
    logic [32:0] cfg_clamped;
    logic [WIDX_W-1:0] wj_idx;
    logic        fits;

    cba_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        ps64       = {31'b0, ps_reg};
        al64       = {47'b0, al_reg};
        rem64      = {31'b0, div_rsp.remainder};
        oldest_lim = oldest_reg + ps64;
        txn_sum    = txn_bytes_reg + {32'b0, nb_reg};
        half_pool  = ps64 >> 1;
        fits       = en_reg <= oldest_lim;
        wj_idx     = wj_reg[WIDX_W-1:0];
        if (cfg_wr_data == '0)
            cfg_clamped = 33'd1;
        else if (cfg_wr_data[32] && (cfg_wr_data[31:0] != '0))
            cfg_clamped = cba_pkg::POOL_MAX;
        else
            cfg_clamped = cfg_wr_data;
    end

    // divider operand selection
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = st_reg;
        div_req.divisor  = {16'b0, al_reg};
        unique case (state_reg)
            S_AL_MODA:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ps64;
            end
            S_AL_RA, S_AL_RB:
                div_req.start = 1'b1;
            S_AL_Q0:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = ps_reg;
            end
            S_AL_Q1:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = en_reg - 64'd1;
                div_req.divisor  = ps_reg;
            end
            S_AL_OFS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = sa_reg;
                div_req.divisor  = ps_reg;
            end
            S_FR_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = bsa_reg[idx_reg];
                div_req.divisor  = ps_reg;
            end
            S_TE:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = fill_reg;
                div_req.divisor  = ps_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ps_reg         <= cba_pkg::POOL_RESET;
            fill_reg       <= '0;
            oldest_reg     <= '0;
            txn_limit_reg  <= '1;
            txn_bytes_reg  <= '0;
            txn_active_reg <= 1'b0;
            rewrap_reg     <= 1'b0;
            live_cnt_reg   <= '0;
            wcnt_reg       <= '0;
            for (int k = 0; k < MAX_BLOCKS; k++)
            begin
                bst_reg[k] <= '0;
                bsa_reg[k] <= '0;
            end
            for (int k = 0; k < MAX_WAITING; k++)
            begin
                wend_reg[k] <= '0;
                wofs_reg[k] <= '0;
            end
            op_reg         <= '0;
            nb_reg         <= '0;
            fo_reg         <= '0;
            al_reg         <= '0;
            st_reg         <= '0;
            sa_reg         <= '0;
            en_reg         <= '0;
            q0_reg         <= '0;
            rup_reg        <= '0;
            ofs_reg        <= '0;
            idx_reg        <= '0;
            wj_reg         <= '0;
            kept_reg       <= '0;
            mask_reg       <= '0;
            res_kind_reg   <= '0;
            res_status_reg <= '0;
            res_offset_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= '0;
            out_status_reg <= '0;
            out_offset_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                ps_reg <= cfg_clamped;
            if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= req.op;
                        nb_reg    <= req.block_size;
                        al_reg    <= req.align;
                        fo_reg    <= req.free_offset;
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    res_offset_reg <= '0;
                    res_status_reg <= cba_pkg::ST_OK;
                    unique case (op_reg)
                        cba_pkg::OP_ALLOC:
                        begin
                            res_kind_reg <= cba_pkg::KIND_ALLOC;
                            if (nb_reg == '0)
                            begin
                                res_status_reg <= cba_pkg::ST_NULL;
                                state_reg      <= S_REPLY;
                            end
                            else if ({1'b0, nb_reg} > ps_reg)
                            begin
                                res_status_reg <= cba_pkg::ST_TOO_LARGE;
                                state_reg      <= S_REPLY;
                            end
                            else if (al_reg == '0)
                            begin
                                res_status_reg <= cba_pkg::ST_BAD_ALIGN;
                                state_reg      <= S_REPLY;
                            end
                            else
                                state_reg <= S_AL_MODA;
                        end
                        cba_pkg::OP_FREE:
                        begin
                            res_kind_reg   <= cba_pkg::KIND_FREE;
                            res_offset_reg <= fo_reg;
                            idx_reg        <= '0;
                            if (live_cnt_reg == '0)
                            begin
                                res_status_reg <= cba_pkg::ST_BAD_FREE;
                                state_reg      <= S_REPLY;
                            end
                            else
                                state_reg <= S_FR_DIV;
                        end
                        cba_pkg::OP_TXN_BEGIN:
                        begin
                            res_kind_reg   <= cba_pkg::KIND_TXN;
                            txn_limit_reg  <= fill_reg + ps64;
                            txn_bytes_reg  <= '0;
                            txn_active_reg <= 1'b1;
                            state_reg      <= S_REPLY;
                        end
                        cba_pkg::OP_TXN_END:
                        begin
                            res_kind_reg   <= cba_pkg::KIND_TXN;
                            txn_active_reg <= 1'b0;
                            txn_bytes_reg  <= '0;
                            state_reg      <= rewrap_reg ? S_TE : S_REPLY;
                        end
                        default:
                            state_reg <= S_REPLY;
                    endcase
                end

                S_AL_MODA:
                    state_reg <= S_AL_MODA_W;
                S_AL_MODA_W:
                begin
                    if (div_rsp.done)
                    begin
                        st_reg <= fill_reg;
                        if (div_rsp.remainder != '0)
                        begin
                            res_status_reg <= cba_pkg::ST_BAD_ALIGN;
                            state_reg      <= S_REPLY;
                        end
                        else
                            state_reg <= S_AL_RA;
                    end
                end

                S_AL_RA, S_AL_RB:
                    state_reg <= (state_reg == S_AL_RA) ? S_AL_RA_W : S_AL_RB_W;
                S_AL_RA_W, S_AL_RB_W:
                begin
                    if (div_rsp.done)
                    begin
                        if (div_rsp.remainder != '0)
                        begin
                            sa_reg <= st_reg + (al64 - rem64);
                            en_reg <= st_reg + (al64 - rem64) + {32'b0, nb_reg};
                        end
                        else
                        begin
                            sa_reg <= st_reg;
                            en_reg <= st_reg + {32'b0, nb_reg};
                        end
                        state_reg <= (state_reg == S_AL_RA_W) ? S_AL_Q0 : S_AL_OFS;
                    end
                end

                S_AL_Q0:
                    state_reg <= S_AL_Q0_W;
                S_AL_Q0_W:
                begin
                    if (div_rsp.done)
                    begin
                        q0_reg    <= div_rsp.quotient;
                        rup_reg   <= (div_rsp.remainder != '0) ?
                                     st_reg + (ps64 - rem64) : st_reg;
                        state_reg <= S_AL_Q1;
                    end
                end

                S_AL_Q1:
                    state_reg <= S_AL_Q1_W;
                S_AL_Q1_W:
                begin
                    if (div_rsp.done)
                    begin
                        // block crosses a pool boundary: restart at the next one
                        if (div_rsp.quotient > q0_reg)
                        begin
                            st_reg    <= rup_reg;
                            state_reg <= S_AL_RB;
                        end
                        else
                            state_reg <= S_AL_OFS;
                    end
                end

                S_AL_OFS:
                    state_reg <= S_AL_OFS_W;
                S_AL_OFS_W:
                begin
                    if (div_rsp.done)
                    begin
                        ofs_reg   <= div_rsp.remainder[31:0];
                        state_reg <= S_AL_COMMIT;
                    end
                end

                S_AL_COMMIT:
                begin
                    state_reg <= S_REPLY;
                    if ((txn_active_reg && (en_reg > txn_limit_reg))
                        || (live_cnt_reg == CNT_W'(MAX_BLOCKS))
                        || (!fits && (wcnt_reg == WCNT_W'(MAX_WAITING))))
                        res_status_reg <= cba_pkg::ST_FULL;
                    else
                    begin
                        for (int k = 0; k < MAX_BLOCKS; k++)
                        begin
                            if (CNT_W'(k) == live_cnt_reg)
                            begin
                                bst_reg[k] <= st_reg;
                                bsa_reg[k] <= sa_reg;
                            end
                        end
                        live_cnt_reg   <= live_cnt_reg + CNT_W'(1);
                        fill_reg       <= en_reg;
                        res_offset_reg <= ofs_reg;
                        if (txn_active_reg)
                        begin
                            txn_bytes_reg <= txn_sum;
                            if (txn_sum > half_pool)
                                rewrap_reg <= 1'b1;
                        end
                        if (fits)
                            res_status_reg <= cba_pkg::ST_OK;
                        else
                        begin
                            for (int k = 0; k < MAX_WAITING; k++)
                            begin
                                if (WCNT_W'(k) == wcnt_reg)
                                begin
                                    wend_reg[k] <= en_reg;
                                    wofs_reg[k] <= ofs_reg;
                                end
                            end
                            wcnt_reg       <= wcnt_reg + WCNT_W'(1);
                            res_status_reg <= cba_pkg::ST_WAITING;
                        end
                    end
                end

                S_FR_DIV:
                    state_reg <= S_FR_DIV_W;
                S_FR_DIV_W:
                begin
                    if (div_rsp.done)
                    begin
                        if (div_rsp.remainder == {1'b0, fo_reg})
                        begin
                            for (int k = 0; k < MAX_BLOCKS - 1; k++)
                            begin
                                if (BIDX_W'(k) >= idx_reg)
                                begin
                                    bst_reg[k] <= bst_reg[k+1];
                                    bsa_reg[k] <= bsa_reg[k+1];
                                end
                            end
                            live_cnt_reg <= live_cnt_reg - CNT_W'(1);
                            if (live_cnt_reg == CNT_W'(1))
                            begin
                                oldest_reg <= '0;
                                fill_reg   <= '0;
                            end
                            else if (idx_reg == '0)
                                oldest_reg <= bst_reg[HEAD2];
                            else
                                oldest_reg <= bst_reg[0];
                            wj_reg    <= '0;
                            mask_reg  <= '0;
                            state_reg <= S_FR_MASK;
                        end
                        else if ((CNT_W'(idx_reg) + CNT_W'(1)) == live_cnt_reg)
                        begin
                            res_status_reg <= cba_pkg::ST_BAD_FREE;
                            state_reg      <= S_REPLY;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + BIDX_W'(1);
                            state_reg <= S_FR_DIV;
                        end
                    end
                end

                S_FR_MASK:
                begin
                    mask_reg[wj_idx] <= (wj_reg < wcnt_reg) && (wend_reg[wj_idx] <= oldest_lim);
                    if (wj_reg == WCNT_W'(MAX_WAITING - 1))
                        state_reg <= S_FR_REPLY;
                    else
                        wj_reg <= wj_reg + WCNT_W'(1);
                end

                S_FR_REPLY:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= cba_pkg::KIND_FREE;
                        out_status_reg <= cba_pkg::ST_OK;
                        out_offset_reg <= fo_reg;
                        out_last_reg   <= (mask_reg == '0);
                        wj_reg         <= '0;
                        kept_reg       <= '0;
                        state_reg      <= S_FR_GRANT;
                    end
                end

                S_FR_GRANT:
                begin
                    if (wj_reg == wcnt_reg)
                    begin
                        wcnt_reg  <= kept_reg;
                        state_reg <= S_IDLE;
                    end
                    else if (mask_reg[wj_idx])
                    begin
                        if (!out_valid_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_kind_reg   <= cba_pkg::KIND_GRANT;
                            out_status_reg <= cba_pkg::ST_OK;
                            out_offset_reg <= wofs_reg[wj_idx];
                            out_last_reg   <= ((mask_reg >> (wj_reg + WCNT_W'(1))) == '0);
                            wj_reg         <= wj_reg + WCNT_W'(1);
                        end
                    end
                    else
                    begin
                        // compact the entries still waiting
                        for (int k = 0; k < MAX_WAITING; k++)
                        begin
                            if (WCNT_W'(k) == kept_reg)
                            begin
                                wend_reg[k] <= wend_reg[wj_idx];
                                wofs_reg[k] <= wofs_reg[wj_idx];
                            end
                        end
                        kept_reg <= kept_reg + WCNT_W'(1);
                        wj_reg   <= wj_reg + WCNT_W'(1);
                    end
                end

                S_TE:
                    state_reg <= S_TE_W;
                S_TE_W:
                begin
                    if (div_rsp.done)
                    begin
                        if (div_rsp.remainder != '0)
                            fill_reg <= fill_reg + (ps64 - rem64);
                        state_reg <= S_REPLY;
                    end
                end

                S_REPLY:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= res_kind_reg;
                        out_status_reg <= res_status_reg;
                        out_offset_reg <= res_offset_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.kind   = out_kind_reg;
    assign rsp.status = out_status_reg;
    assign rsp.offset = out_offset_reg;
    assign rsp.last   = out_last_reg;

    `ASSERT_IMPLIES(a_live_bound, 1'b1, live_cnt_reg <= CNT_W'(MAX_BLOCKS), "table count overflow")
    `ASSERT_IMPLIES(a_wait_bound, 1'b1, wcnt_reg <= WCNT_W'(MAX_WAITING), "waiting count overflow")
    `ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_reg == S_DISPATCH,
        "item not dispatched")
    `ASSERT_IMPLIES(a_empty_fill,
        live_cnt_reg == '0 && wcnt_reg == '0 && !txn_active_reg && state_reg == S_IDLE
        && !rewrap_reg,
        oldest_reg == '0, "oldest position set with empty table")

endmodule

@@ tb/tb.sv @@
// testbench for circular_block_allocator: random and directed requests against a
// behavioral predictor of the ring allocator, responses checked item by item
// depends on cba_pkg, cba_if and the allocator rtl
module tb;

    localparam int NBLK = 16;
    localparam int NWAIT = 4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] block_size;
        logic [16:0] align;
        logic [31:0] free_offset;
    } request_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [31:0] offset;
        logic        last;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [32:0] cfg_wr_data;
    int          errors;

    cba_req_if req_ch();
    cba_rsp_if rsp_ch();

    circular_block_allocator DUT (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .req(req_ch.sink), .rsp(rsp_ch.source)
    );

    // predictor state
    logic [63:0] pool;
    logic [63:0] blk_start [NBLK];
    logic [63:0] blk_aligned [NBLK];
    int          blk_count;
    logic [63:0] fill_pos;
    logic [63:0] oldest_pos;
    logic        in_txn;
    logic [63:0] txn_lim;
    logic [63:0] txn_total;
    logic        rewrap;
    logic [63:0] wait_end [NWAIT];
    logic [31:0] wait_ofs [NWAIT];
    int          wait_count;

    request_t pending_reqs[$];
    reply_t   expected_replies[$];
    logic [31:0] live_offsets[$];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] round_to(logic [63:0] x, logic [63:0] a);
        logic [63:0] r;
        r = x % a;
        return (r != 0) ? x + (a - r) : x;
    endfunction

    function automatic void push_reply(logic [1:0] k, logic [2:0] s, logic [31:0] o);
        reply_t r;
        r.kind = k;
        r.status = s;
        r.offset = o;
        r.last = 1'b0;
        expected_replies.push_back(r);
    endfunction

    function automatic void predict_alloc(logic [63:0] nb, logic [63:0] al);
        logic [63:0] st, sa, en, ofs;
        logic fits;
        if (nb == 0)
        begin
            push_reply(cba_pkg::KIND_ALLOC, cba_pkg::ST_NULL, 32'd0);
            return;
        end
        if (nb > pool)
        begin
            push_reply(cba_pkg::KIND_ALLOC, cba_pkg::ST_TOO_LARGE, 32'd0);
            return;
        end
        if (al == 0 || pool % al != 0)
        begin
            push_reply(cba_pkg::KIND_ALLOC, cba_pkg::ST_BAD_ALIGN, 32'd0);
            return;
        end
        st = fill_pos;
        sa = round_to(st, al);
        en = sa + nb;
        if ((en - 1) / pool > st / pool)
        begin
            st = round_to(fill_pos, pool);
            sa = round_to(st, al);
            en = sa + nb;
        end
        fits = en <= oldest_pos + pool;
        if ((in_txn && en > txn_lim) || blk_count >= NBLK || (!fits && wait_count >= NWAIT))
        begin
            push_reply(cba_pkg::KIND_ALLOC, cba_pkg::ST_FULL, 32'd0);
            return;
        end
        ofs = sa % pool;
        blk_start[blk_count] = st;
        blk_aligned[blk_count] = sa;
        blk_count++;
        fill_pos = en;
        live_offsets.push_back(ofs[31:0]);
        if (in_txn)
        begin
            txn_total += nb;
            if (txn_total > pool / 2)
                rewrap = 1'b1;
        end
        if (fits)
            push_reply(cba_pkg::KIND_ALLOC, cba_pkg::ST_OK, ofs[31:0]);
        else
        begin
            wait_end[wait_count] = en;
            wait_ofs[wait_count] = ofs[31:0];
            wait_count++;
            push_reply(cba_pkg::KIND_ALLOC, cba_pkg::ST_WAITING, ofs[31:0]);
        end
    endfunction

    function automatic void predict_free(logic [31:0] fo);
        int i, j, kept;
        i = 0;
        while (i < blk_count && blk_aligned[i] % pool != {32'd0, fo})
            i++;
        push_reply(cba_pkg::KIND_FREE,
                   (i < blk_count) ? cba_pkg::ST_OK : cba_pkg::ST_BAD_FREE, fo);
        if (i >= blk_count)
            return;
        for (j = i; j + 1 < blk_count; j++)
        begin
            blk_start[j] = blk_start[j + 1];
            blk_aligned[j] = blk_aligned[j + 1];
        end
        blk_count--;
        if (blk_count == 0)
        begin
            oldest_pos = 0;
            fill_pos = 0;
        end
        else
            oldest_pos = blk_start[0];
        kept = 0;
        for (j = 0; j < wait_count; j++)
        begin
            if (wait_end[j] <= oldest_pos + pool)
                push_reply(cba_pkg::KIND_GRANT, cba_pkg::ST_OK, wait_ofs[j]);
            else
            begin
                wait_end[kept] = wait_end[j];
                wait_ofs[kept] = wait_ofs[j];
                kept++;
            end
        end
        wait_count = kept;
    endfunction

    function automatic void predict_request(request_t r);
        reply_t tail;
        unique case (r.op)
            cba_pkg::OP_ALLOC: predict_alloc({32'd0, r.block_size}, {47'd0, r.align});
            cba_pkg::OP_FREE: predict_free(r.free_offset);
            cba_pkg::OP_TXN_BEGIN:
            begin
                txn_lim = fill_pos + pool;
                txn_total = 0;
                in_txn = 1'b1;
                push_reply(cba_pkg::KIND_TXN, cba_pkg::ST_OK, 32'd0);
            end
            default:
            begin
                in_txn = 1'b0;
                if (rewrap)
                    fill_pos = round_to(fill_pos, pool);
                txn_total = 0;
                push_reply(cba_pkg::KIND_TXN, cba_pkg::ST_OK, 32'd0);
            end
        endcase
        tail = expected_replies.pop_back();
        tail.last = 1'b1;
        expected_replies.push_back(tail);
    endfunction

    // driver
    int req_gap;
    always @(posedge clk)
    begin
        if (req_ch.valid && req_ch.ready)
        begin
            predict_request(pending_reqs.pop_front());
            req_ch.valid <= 1'b0;
            req_gap = $urandom_range(0, 5);
        end
        else if (!req_ch.valid && rst_n && pending_reqs.size() > 0)
        begin
            if (req_gap > 0)
                req_gap--;
            else
            begin
                req_ch.valid <= 1'b1;
                req_ch.op <= pending_reqs[0].op;
                req_ch.block_size <= pending_reqs[0].block_size;
                req_ch.align <= pending_reqs[0].align;
                req_ch.free_offset <= pending_reqs[0].free_offset;
            end
        end
    end

    // monitor
    int rsp_gap;
    always @(posedge clk)
    begin
        reply_t got, want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            got.kind = rsp_ch.kind;
            got.status = rsp_ch.status;
            got.offset = rsp_ch.offset;
            got.last = rsp_ch.last;
            if (expected_replies.size() == 0)
            begin
                $display("%0t unexpected item: expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.kind !== want.kind)
                begin
                    $display("%0t kind: expected %0d actual %0d", $time, want.kind, got.kind);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t status: expected %0d actual %0d", $time, want.status,
                             got.status);
                    errors++;
                end
                if (got.offset !== want.offset)
                begin
                    $display("%0t offset: expected %h actual %h", $time, want.offset,
                             got.offset);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $display("%0t last: expected %0d actual %0d", $time, want.last, got.last);
                    errors++;
                end
            end
            rsp_gap = $urandom_range(0, 5);
            rsp_ch.ready <= (rsp_gap == 0);
        end
        else if (rsp_gap > 0)
        begin
            rsp_gap--;
            rsp_ch.ready <= (rsp_gap == 0);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    task automatic add_req(logic [1:0] op, logic [31:0] nb, logic [16:0] al,
                           logic [31:0] fo);
        request_t r;
        r.op = op;
        r.block_size = nb;
        r.align = al;
        r.free_offset = fo;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !req_ch.valid);
        wait (expected_replies.size() == 0);
        repeat (2000) @(posedge clk);
    endtask

    task automatic write_pool(logic [32:0] v);
        logic [63:0] p;
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        p = {31'd0, v};
        if (p == 0)
            p = 1;
        if (p > 64'h1_0000_0000)
            p = 64'h1_0000_0000;
        pool = p;
    endtask

    // random phase tuned to a power-of-two pool
    task automatic random_phase(int count, int shift);
        int i, sel;
        logic [31:0] nb;
        for (i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
            begin
                if ($urandom_range(0, 9) == 0)
                    nb = $urandom;
                else
                    nb = $urandom_range(1, (1 << shift) / 3 + 1);
                add_req(cba_pkg::OP_ALLOC, nb,
                        ($urandom_range(0, 9) == 0) ? 17'($urandom)
                                                    : 17'(1 << $urandom_range(0, shift)),
                        0);
            end
            else if (sel < 85)
            begin
                if (live_offsets.size() > 0 && $urandom_range(0, 7) != 0)
                    add_req(cba_pkg::OP_FREE, 0, 0,
                            live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
                else
                    add_req(cba_pkg::OP_FREE, 0, 0, $urandom);
            end
            else if (sel < 93)
                add_req(cba_pkg::OP_TXN_BEGIN, $urandom, 17'($urandom), $urandom);
            else
                add_req(cba_pkg::OP_TXN_END, $urandom, 17'($urandom), $urandom);
            if (pending_reqs.size() > 4)
                wait (pending_reqs.size() <= 4);
        end
    endtask

    initial
    begin
        errors = 0;
        req_gap = 0;
        rsp_gap = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.op = cba_pkg::OP_ALLOC;
        req_ch.block_size = '0;
        req_ch.align = '0;
        req_ch.free_offset = '0;
        rsp_ch.ready = 1'b0;
        pool = 64'd65536;
        blk_count = 0;
        fill_pos = 0;
        oldest_pos = 0;
        in_txn = 1'b0;
        txn_lim = '1;
        txn_total = 0;
        rewrap = 1'b0;
        wait_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, errors, waiting, grants and transactions
        add_req(cba_pkg::OP_ALLOC, 0, 1, 0);
        add_req(cba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1, 0);
        add_req(cba_pkg::OP_ALLOC, 16, 0, 0);
        add_req(cba_pkg::OP_ALLOC, 16, 3, 0);
        add_req(cba_pkg::OP_ALLOC, 16, 17'h10000, 0);
        add_req(cba_pkg::OP_ALLOC, 100, 1, 0);
        add_req(cba_pkg::OP_ALLOC, 40000, 64, 0);
        add_req(cba_pkg::OP_ALLOC, 30000, 16, 0);
        add_req(cba_pkg::OP_ALLOC, 30000, 16, 0);
        add_req(cba_pkg::OP_FREE, 0, 0, 32'hFFFF_FFFF);
        add_req(cba_pkg::OP_FREE, 0, 0, 0);
        add_req(cba_pkg::OP_FREE, 0, 0, 128);
        add_req(cba_pkg::OP_TXN_END, 0, 0, 0);
        add_req(cba_pkg::OP_TXN_BEGIN, 0, 0, 0);
        add_req(cba_pkg::OP_ALLOC, 40000, 1, 0);
        add_req(cba_pkg::OP_ALLOC, 65536, 1, 0);
        add_req(cba_pkg::OP_TXN_BEGIN, 0, 0, 0);
        add_req(cba_pkg::OP_TXN_END, 0, 0, 0);
        add_req(cba_pkg::OP_FREE, 0, 0, 0);
        drain();
        write_pool(33'd4096);
        random_phase(150, 12);
        drain();
        write_pool(33'd0);
        add_req(cba_pkg::OP_ALLOC, 1, 1, 0);
        add_req(cba_pkg::OP_ALLOC, 1, 2, 0);
        add_req(cba_pkg::OP_ALLOC, 2, 1, 0);
        add_req(cba_pkg::OP_FREE, 0, 0, 0);
        drain();
        write_pool(33'h1_FFFF_FFFF);
        add_req(cba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 17'h10000, 0);
        add_req(cba_pkg::OP_ALLOC, 32'h8000_0000, 17'h10000, 0);
        add_req(cba_pkg::OP_FREE, 0, 0, 0);
        random_phase(40, 16);
        drain();
        write_pool(33'd256);
        random_phase(150, 8);
        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/cba_pkg.sv
src/cba_if.sv
src/cba_div.sv
src/circular_block_allocator.sv
tb/tb.sv
